@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the safety check block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BSC_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("bsc assertion failed");

// expression must never be true outside reset
`define BSC_ASSERT_NEVER(label, clk_s, rst_s, expr) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("bsc forbidden condition seen");

`endif

@@ rtl/bsc_pkg.sv @@
// ---------------------------------------------------------------------------
// bsc_pkg
// Types, sizes and codes shared by the safety check modules.
// ---------------------------------------------------------------------------
package bsc_pkg;

  localparam int THREAD_COUNT = 8;
  localparam int RES_KINDS    = 4;
  localparam int COUNT_BITS   = 8;

  localparam int THREAD_BITS = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int PLACED_BITS = $clog2(THREAD_COUNT + 1);
  // avail plus every allocation added back cannot exceed this width
  localparam int WORK_BITS   = COUNT_BITS + $clog2(THREAD_COUNT + 1);

  // port field widths (fixed by the interface)
  localparam int IDX_W    = 3;
  localparam int FIELD_W  = 8;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;
  localparam int STATUS_W   = 3;
  localparam int ADDR_W     = 4;
  localparam int APB_DATA_W = 32;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_LOAD_OK   = 3'd0,
    STAT_LOAD_OVER = 3'd1,
    STAT_ORDER     = 3'd2,
    STAT_SAFE      = 3'd3,
    STAT_DEADLOCK  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END
  } state_t;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef cnt_t [RES_KINDS-1:0]  row_t;
  typedef logic [WORK_BITS-1:0]  work_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // write row, queue load result
    logic start;      // open a check
    logic step;       // test thread under the scan pointer
    logic emit_safe;  // queue the closing safe result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a result
    logic cand;        // scanned thread is unfinished and fits
    logic scan_last;   // scan pointer on the last thread
    logic last_place;  // one thread left to place
  } dp_stat_t;

endpackage

@@ rtl/bankers_safety_check_top.sv @@
// ---------------------------------------------------------------------------
// bankers_safety_check_top
// Banker's algorithm safety check: thread row loads and safe-order search.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  ---------------------------------------
//  s_*       in   s_tvalid / s_tready    tuser: req_type; tdata: index, alloc, max
//  m_*       out  m_tvalid / m_tready    tuser: status; tdata: order_thread; tlast
//  APB       in   psel/penable/pready    avail_res0..3 at 0x0, 0x4, 0x8, 0xC
//
//  A load queues a single result.
//  A check scans one thread per cycle and restarts at thread 0 after each
//  placement. It ends with a safe result, or with a deadlock result when a
//  scan reaches the last thread with no unfinished thread that fits.
//  Any cycle in which the result register is full and not taken stalls the
//  scan. Reset is synchronous and active high; it zeroes the tables, the
//  config and check registers and the result valid flag.
//
module bankers_safety_check_top (
  input  logic                               clk,
  input  logic                               rst,
  // input item
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [2:0] thread_index, [10:3] alloc_res0, [18:11] alloc_res1,
  // [26:19] alloc_res2, [34:27] alloc_res3, [42:35] max_res0,
  // [50:43] max_res1, [58:51] max_res2, [66:59] max_res3, [71:67] zero
  input  logic [bsc_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [0:0]                         s_tuser,   // [0] req_type
  // result item
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bsc_pkg::OUT_DATA_W-1:0]     m_tdata,   // [2:0] order_thread, [7:3] zero
  output logic [bsc_pkg::STATUS_W-1:0]       m_tuser,   // [2:0] status
  output logic                               m_tlast,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0]         paddr,
  input  logic [bsc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bsc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  bsc_pkg::ctrl_cmd_t cmd;
  bsc_pkg::dp_stat_t  stat;
  logic               cfg_wr;

  // no wait states; write lands in the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser[0]),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .cfg_wr   (cfg_wr),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/bsc_ctrl.sv @@
// ---------------------------------------------------------------------------
// bsc_ctrl
// Sequencer for loads and safety check passes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               req_type,
  output logic               s_tready,
  input  bsc_pkg::dp_stat_t  stat,
  output bsc_pkg::ctrl_cmd_t cmd
);

  bsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bsc_pkg::ST_IDLE: begin
        if (s_tvalid && stat.out_free && req_type == bsc_pkg::REQ_CHECK) begin
          state_next = bsc_pkg::ST_SCAN;
        end
      end
      bsc_pkg::ST_SCAN: begin
        if (stat.out_free) begin
          if (stat.cand && stat.last_place) begin
            state_next = bsc_pkg::ST_END;
          end else if (!stat.cand && stat.scan_last) begin
            state_next = bsc_pkg::ST_IDLE;   // deadlock reported
          end
        end
      end
      bsc_pkg::ST_END: begin
        if (stat.out_free) begin
          state_next = bsc_pkg::ST_IDLE;
        end
      end
      default: state_next = bsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      bsc_pkg::ST_IDLE: begin
        s_tready = stat.out_free;
        if (s_tvalid && stat.out_free) begin
          cmd.load  = (req_type == bsc_pkg::REQ_LOAD);
          cmd.start = (req_type == bsc_pkg::REQ_CHECK);
        end
      end
      bsc_pkg::ST_SCAN: cmd.step      = stat.out_free;
      bsc_pkg::ST_END:  cmd.emit_safe = stat.out_free;
      default: ;
    endcase
  end

  `BSC_ASSERT(a_ready_only_idle, clk, rst, s_tready |-> state == bsc_pkg::ST_IDLE)

endmodule

@@ rtl/bsc_dp.sv @@
// ---------------------------------------------------------------------------
// bsc_dp
// Tables, work vector, scan counters, config registers and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  bsc_pkg::ctrl_cmd_t                 cmd,
  output bsc_pkg::dp_stat_t                  stat,
  input  logic [bsc_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               cfg_wr,
  input  logic [bsc_pkg::ADDR_W-1:0]         paddr,
  input  logic [bsc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bsc_pkg::APB_DATA_W-1:0]     prdata,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [bsc_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [bsc_pkg::STATUS_W-1:0]       m_tuser,
  output logic                               m_tlast
);

  localparam int TB = bsc_pkg::THREAD_BITS;
  localparam int RK = bsc_pkg::RES_KINDS;
  localparam int FW = bsc_pkg::FIELD_W;
  localparam int IW = bsc_pkg::IDX_W;

  bsc_pkg::row_t  alloc_tab [bsc_pkg::THREAD_COUNT];
  bsc_pkg::row_t  need_tab  [bsc_pkg::THREAD_COUNT];
  bsc_pkg::cnt_t  avail     [RK];
  bsc_pkg::work_t work      [RK];

  logic [bsc_pkg::THREAD_COUNT-1:0] finished;
  logic [bsc_pkg::PLACED_BITS-1:0]  placed;
  logic [TB-1:0]                    scan_idx;

  logic                    out_valid;
  bsc_pkg::status_t        out_status;
  logic [IW-1:0]           out_thread;
  logic                    out_last;

  // load decode
  logic [IW-1:0]   ld_idx;
  logic [TB-1:0]   ld_row;
  logic            ld_in_range;
  bsc_pkg::row_t   ld_alloc, ld_need;
  logic            ld_over;
  bsc_pkg::cnt_t   ld_max;

  always_comb begin
    ld_idx      = s_tdata[IW-1:0];
    ld_row      = TB'(ld_idx);
    ld_in_range = int'(ld_idx) < bsc_pkg::THREAD_COUNT;
    ld_over     = 1'b0;
    for (int r = 0; r < RK; r++) begin
      ld_alloc[r] = bsc_pkg::COUNT_BITS'(s_tdata[IW + r*FW +: FW]);
      ld_max      = bsc_pkg::COUNT_BITS'(s_tdata[IW + (RK + r)*FW +: FW]);
      if (ld_alloc[r] > ld_max) begin
        ld_need[r] = '0;
        ld_over    = 1'b1;
      end else begin
        ld_need[r] = ld_max - ld_alloc[r];
      end
    end
  end

  // fit test of the thread under the scan pointer
  logic fit;
  always_comb begin
    fit = 1'b1;
    for (int r = 0; r < RK; r++) begin
      if (bsc_pkg::WORK_BITS'(need_tab[scan_idx][r]) > work[r]) fit = 1'b0;
    end
  end

  always_comb begin
    stat.out_free   = !out_valid || m_tready;
    stat.cand       = !finished[scan_idx] && fit;
    stat.scan_last  = int'(scan_idx) == bsc_pkg::THREAD_COUNT - 1;
    stat.last_place = int'(placed) == bsc_pkg::THREAD_COUNT - 1;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RK; r++) avail[r] <= '0;
    end else if (cfg_wr) begin
      for (int r = 0; r < RK; r++) begin
        if (int'(paddr[bsc_pkg::ADDR_W-1:2]) == r) begin
          avail[r] <= bsc_pkg::COUNT_BITS'(pwdata);
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int r = 0; r < RK; r++) begin
      if (int'(paddr[bsc_pkg::ADDR_W-1:2]) == r) prdata = bsc_pkg::APB_DATA_W'(avail[r]);
    end
  end

  // thread tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < bsc_pkg::THREAD_COUNT; t++) begin
        alloc_tab[t] <= '0;
        need_tab[t]  <= '0;
      end
    end else if (cmd.load && ld_in_range) begin
      alloc_tab[ld_row] <= ld_alloc;
      need_tab[ld_row]  <= ld_need;
    end
  end

  // check state
  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= '0;
      placed   <= '0;
      scan_idx <= '0;
      for (int r = 0; r < RK; r++) work[r] <= '0;
    end else if (cmd.start) begin
      finished <= '0;
      placed   <= '0;
      scan_idx <= '0;
      for (int r = 0; r < RK; r++) work[r] <= bsc_pkg::WORK_BITS'(avail[r]);
    end else if (cmd.step) begin
      if (stat.cand) begin
        finished[scan_idx] <= 1'b1;
        placed             <= placed + 1'b1;
        scan_idx           <= '0;   // next pass restarts at the lowest thread
        for (int r = 0; r < RK; r++) begin
          work[r] <= work[r] + bsc_pkg::WORK_BITS'(alloc_tab[scan_idx][r]);
        end
      end else if (!stat.scan_last) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // result register
  logic out_load;
  assign out_load = cmd.load || cmd.emit_safe ||
                    (cmd.step && (stat.cand || stat.scan_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status <= (ld_in_range && ld_over) ? bsc_pkg::STAT_LOAD_OVER
                                             : bsc_pkg::STAT_LOAD_OK;
      out_thread <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_safe) begin
      out_status <= bsc_pkg::STAT_SAFE;
      out_thread <= '0;
      out_last   <= 1'b1;
    end else if (cmd.step && stat.cand) begin
      out_status <= bsc_pkg::STAT_ORDER;
      out_thread <= IW'(scan_idx);
      out_last   <= 1'b0;
    end else if (cmd.step && stat.scan_last) begin
      out_status <= bsc_pkg::STAT_DEADLOCK;
      out_thread <= '0;
      out_last   <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = bsc_pkg::OUT_DATA_W'(out_thread);
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  `BSC_ASSERT(a_placed_matches_flags, clk, rst, $countones(finished) == int'(placed))
  `BSC_ASSERT_NEVER(a_order_not_last, clk, rst,
                    out_valid && out_status == bsc_pkg::STAT_ORDER && out_last)

endmodule
